/* src/shpl_pkg.sv */
// ----------------------------------------------------------------------------
// shpl_pkg
// Shared types, character codes and hex decode helpers for the serial hex
// packet line parser.
// ----------------------------------------------------------------------------
package shpl_pkg;

    localparam int STORE_DEPTH = 60;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = 7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [7:0] OFS_UPPER = 8'd55;
    localparam logic [7:0] OFS_LOWER = 8'd87;
    localparam logic [7:0] OFS_DIGIT = 8'd48;

    localparam logic [CNT_W-1:0] POS_OPEN  = 7'd0;
    localparam logic [CNT_W-1:0] POS_RSSI  = 7'd2;
    localparam logic [CNT_W-1:0] POS_LQI   = 7'd4;
    localparam logic [CNT_W-1:0] POS_CLOSE = 7'd5;
    localparam logic [CNT_W-1:0] POS_HDR   = 7'd6;
    localparam logic [CNT_W-1:0] POS_DATA  = 7'd7;

    // controller -> datapath
    typedef struct packed {
        logic              accept;
        logic              latch;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic             line_end;
        logic [LEN_W-1:0] emit_len;
    } dp_stat_t;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - OFS_UPPER;
            return {1'b0, d[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - OFS_LOWER;
            return {1'b0, d[3:0]};
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - OFS_DIGIT;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] h;
        logic [4:0] l;
        h = nibble_of(hi);
        l = nibble_of(lo);
        if (h[4] || l[4]) begin
            return 8'h00;
        end
        return {h[3:0], l[3:0]};
    endfunction

endpackage

/* src/shpl_datapath.sv */
// ----------------------------------------------------------------------------
// shpl_datapath
// Line decode registers, data byte store and result field registers.
// ----------------------------------------------------------------------------
module shpl_datapath #(
    parameter int LINE_CHARS = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [7:0]                         rx_byte,
    input  shpl_pkg::ctl_cmd_t                 cmd,
    output shpl_pkg::dp_stat_t                 stat,
    output logic                               is_packet,
    output logic [7:0]                         rssi,
    output logic [7:0]                         lqi,
    output logic [shpl_pkg::LEN_W-1:0]         packet_length,
    output logic [7:0]                         data_byte
);

    localparam logic [shpl_pkg::CNT_W-1:0] FULL_POS = shpl_pkg::CNT_W'(LINE_CHARS - 1);

    logic [shpl_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        open_reg, open_next;
    logic                        close_reg, close_next;
    logic [7:0]                  rssi_reg, rssi_next;
    logic [7:0]                  lqi_reg, lqi_next;
    logic [7:0]                  pend_reg, pend_next;

    logic                        out_pkt_reg;
    logic [7:0]                  out_rssi_reg;
    logic [7:0]                  out_lqi_reg;
    logic [shpl_pkg::LEN_W-1:0]  out_len_reg;
    logic [7:0]                  rdata_reg;

    logic [7:0]                  mem [shpl_pkg::STORE_DEPTH];

    logic                        full;
    logic                        packet;
    logic [shpl_pkg::CNT_W-1:0]  body;
    logic [shpl_pkg::CNT_W-1:0]  data_off;
    logic [7:0]                  pair;
    logic                        wr_en;
    logic [shpl_pkg::ADDR_W-1:0] wr_addr;

    assign full     = (cnt_reg >= FULL_POS);
    assign packet   = open_reg && close_reg && (cnt_reg >= shpl_pkg::POS_HDR);
    assign body     = cnt_reg - shpl_pkg::POS_HDR;
    assign data_off = cnt_reg - shpl_pkg::POS_DATA;
    assign pair     = shpl_pkg::pair_value(pend_reg, rx_byte);

    assign stat.line_end = !full && (rx_byte == shpl_pkg::CH_CR);
    assign stat.emit_len = packet ? body[shpl_pkg::LEN_W:1] : '0;

    assign wr_en   = cmd.accept && !full && (rx_byte != shpl_pkg::CH_CR)
                     && (rx_byte != shpl_pkg::CH_LF)
                     && (cnt_reg >= shpl_pkg::POS_DATA) && cnt_reg[0];
    assign wr_addr = data_off[shpl_pkg::ADDR_W:1];

    always_comb begin
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        close_next = close_reg;
        rssi_next  = rssi_reg;
        lqi_next   = lqi_reg;
        pend_next  = pend_reg;
        if (cmd.accept) begin
            if (full || rx_byte == shpl_pkg::CH_CR) begin
                // drop the line
                cnt_next   = '0;
                open_next  = 1'b0;
                close_next = 1'b0;
                rssi_next  = '0;
                lqi_next   = '0;
                pend_next  = '0;
            end else if (rx_byte != shpl_pkg::CH_LF) begin
                if (cnt_reg == shpl_pkg::POS_OPEN) begin
                    open_next = (rx_byte == shpl_pkg::CH_OPEN);
                end else if (cnt_reg == shpl_pkg::POS_CLOSE) begin
                    close_next = (rx_byte == shpl_pkg::CH_CLOSE);
                end else if (cnt_reg == shpl_pkg::POS_RSSI) begin
                    rssi_next = pair;
                end else if (cnt_reg == shpl_pkg::POS_LQI) begin
                    lqi_next = pair;
                end
                pend_next = rx_byte;
                cnt_next  = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            open_reg  <= 1'b0;
            close_reg <= 1'b0;
            rssi_reg  <= '0;
            lqi_reg   <= '0;
            pend_reg  <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            rssi_reg  <= rssi_next;
            lqi_reg   <= lqi_next;
            pend_reg  <= pend_next;
        end
    end

    // result fields, captured at line end
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            out_pkt_reg  <= packet;
            out_rssi_reg <= packet ? rssi_reg : 8'h00;
            out_lqi_reg  <= packet ? lqi_reg : 8'h00;
            out_len_reg  <= stat.emit_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= pair;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    assign is_packet     = out_pkt_reg;
    assign rssi          = out_rssi_reg;
    assign lqi           = out_lqi_reg;
    assign packet_length = out_len_reg;
    assign data_byte     = (out_len_reg == '0) ? 8'h00 : rdata_reg;

endmodule

/* src/shpl_ctrl.sv */
// ----------------------------------------------------------------------------
// shpl_ctrl
// Handshake controller: takes characters, sequences the store reads and
// result transfers after a line end.
// ----------------------------------------------------------------------------
module shpl_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  shpl_pkg::dp_stat_t          stat,
    output shpl_pkg::ctl_cmd_t          cmd,
    output logic [shpl_pkg::LEN_W-1:0]  byte_index,
    output logic                        last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    state_t                      state_reg;
    logic [shpl_pkg::ADDR_W-1:0] k_reg;
    logic [shpl_pkg::LEN_W-1:0]  len_reg;
    logic                        accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);
    assign accept  = s_valid && s_ready;
    assign last    = (len_reg == '0) || ((k_reg + 1'b1) == len_reg);

    assign cmd.accept  = accept;
    assign cmd.latch   = accept && stat.line_end;
    assign cmd.rd_en   = (state_reg == ST_READ);
    assign cmd.rd_addr = k_reg;

    assign byte_index = k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            len_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && stat.line_end) begin
                        k_reg   <= '0;
                        len_reg <= stat.emit_len;
                        state_reg <= (stat.emit_len == '0) ? ST_SEND : ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_ready) begin
                        if (last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_read_then_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_SEND))
        else $error("store read not followed by a result");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((len_reg == '0 && k_reg == '0) || (k_reg < len_reg)))
        else $error("byte index beyond packet length");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(k_reg) && $stable(len_reg)))
        else $error("result sequence advanced during stall");

endmodule

/* src/serial_hex_packet_line_parser_unit.sv */
// ----------------------------------------------------------------------------
// serial_hex_packet_line_parser_unit
// Assembles received serial characters into text lines and emits decoded
// packet data bytes at each line end.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready, s_rx_byte): one received character per
// transfer. While no line end is being answered, s_ready is high and a
// character is taken every cycle. LF is skipped, CR closes the line.
// Result channel (m_valid/m_ready, m_* fields): at CR a packet line gives
// one transfer per data byte (or one with packet_length 0 when it has no
// data); any other line gives a single transfer with m_is_packet low.
// m_last marks the final transfer of a line end.
// After CR the controller moves straight to the output state for an empty
// or non-packet line, and through a data store read first otherwise. Each
// further byte takes a store read and an output state plus any receiver stall.
// s_ready stays low from CR until the last result transfer completes.
// A stalled receiver simply holds m_valid and all fields steady.
// Reset (aresetn low, synchronous) clears the line state and the
// controller; the data store needs no clearing since a packet reads only
// the entries written during its own line.
// ----------------------------------------------------------------------------
module serial_hex_packet_line_parser_unit #(
    parameter int LINE_CHARS = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_packet,
    output logic [7:0] m_rssi,
    output logic [7:0] m_lqi,
    output logic [5:0] m_packet_length,
    output logic [5:0] m_byte_index,
    output logic [7:0] m_data_byte,
    output logic       m_last
);

    shpl_pkg::ctl_cmd_t cmd;
    shpl_pkg::dp_stat_t stat;

    // controller: transfer sequencing and store read addressing
    shpl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd),
        .byte_index (m_byte_index),
        .last       (m_last)
    );

    // datapath: line decode, data store, result field registers
    shpl_datapath #(
        .LINE_CHARS (LINE_CHARS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rx_byte       (s_rx_byte),
        .cmd           (cmd),
        .stat          (stat),
        .is_packet     (m_is_packet),
        .rssi          (m_rssi),
        .lqi           (m_lqi),
        .packet_length (m_packet_length),
        .data_byte     (m_data_byte)
    );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - serial hex packet line parser testbench
// Drives received characters into the parser and predicts the decoded
// results of every line end. A short scripted sequence checks the reset
// state, character extremes and the framing cases. Random packets, broken
// frames, noise lines and full-length lines follow. Both channels stall at
// random, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int  LINE_CHARS     = 128;
    localparam real CLK_PERIOD     = 4.0;
    localparam int  ITEM_TARGET    = 390;   // scripted rows plus random characters
    localparam int  MIN_LINES      = 10;    // reach the overrun line in any case
    localparam int  IDLE_PCT       = 20;
    localparam int  WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int  DRAIN_CYCLES   = 16;
    localparam int  SCRIPT_ROWS    = 24;

    // One result transfer, laid out in port order.
    typedef struct packed {
        logic       is_packet;
        logic [7:0] rssi;
        logic [7:0] lqi;
        logic [5:0] packet_length;
        logic [5:0] byte_index;
        logic [7:0] data_byte;
        logic       last;
    } line_result_t;

    // Scripted character; a typed row carries its one known result.
    typedef struct packed {
        logic [7:0]   ch;
        logic         typed;
        line_result_t want;
    } script_row_t;

    localparam line_result_t NO_RESULT   = '0;
    localparam line_result_t BLANK_LINE  = {1'b0, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00, 1'b1};
    localparam line_result_t BARE_PACKET = {1'b1, 8'hFF, 8'h00, 6'd0, 6'd0, 8'h00, 1'b1};

    // ------------------------------------------------------------------------
    // Scripted sequence: an empty line straight after reset, a line of the
    // extreme characters, a packet with no data, and a packet with a non-hex
    // LQI pair, an LF inside the data, a non-hex data pair and an odd
    // trailing character.
    // ------------------------------------------------------------------------
    script_row_t script_rows [SCRIPT_ROWS] = '{
        {shpl_pkg::CH_CR,    1'b1, BLANK_LINE},
        {8'h00,              1'b0, NO_RESULT},
        {8'hFF,              1'b0, NO_RESULT},
        {shpl_pkg::CH_CR,    1'b1, BLANK_LINE},
        {shpl_pkg::CH_OPEN,  1'b0, NO_RESULT},
        {"F",                1'b0, NO_RESULT},
        {"f",                1'b0, NO_RESULT},
        {"0",                1'b0, NO_RESULT},
        {"0",                1'b0, NO_RESULT},
        {shpl_pkg::CH_CLOSE, 1'b0, NO_RESULT},
        {shpl_pkg::CH_CR,    1'b1, BARE_PACKET},
        {shpl_pkg::CH_OPEN,  1'b0, NO_RESULT},
        {"a",                1'b0, NO_RESULT},
        {"9",                1'b0, NO_RESULT},
        {"G",                1'b0, NO_RESULT},
        {"1",                1'b0, NO_RESULT},
        {shpl_pkg::CH_CLOSE, 1'b0, NO_RESULT},
        {"F",                1'b0, NO_RESULT},
        {"F",                1'b0, NO_RESULT},
        {shpl_pkg::CH_LF,    1'b0, NO_RESULT},
        {"z",                1'b0, NO_RESULT},
        {"7",                1'b0, NO_RESULT},
        {"5",                1'b0, NO_RESULT},
        {shpl_pkg::CH_CR,    1'b0, NO_RESULT}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_is_packet;
    logic [7:0] m_rssi;
    logic [7:0] m_lqi;
    logic [5:0] m_packet_length;
    logic [5:0] m_byte_index;
    logic [7:0] m_data_byte;
    logic       m_last;

    // Line decoder state mirrored by the predictor.
    logic [shpl_pkg::CNT_W-1:0] line_len;
    logic                       saw_open;
    logic                       saw_close;
    logic [7:0]                 rssi_acc;
    logic [7:0]                 lqi_acc;
    logic [7:0]                 prev_char;
    logic [7:0]                 data_mem [shpl_pkg::STORE_DEPTH];

    line_result_t pending_results [$];   // results owed by accepted line ends
    int           mismatches   = 0;
    int           chars_sent   = 0;      // accepted characters other than LF
    int           quiet_cycles = 0;
    bit           steady       = 1'b0;   // suppress idling on both sides

    serial_hex_packet_line_parser_unit #(
        .LINE_CHARS(LINE_CHARS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_packet    (m_is_packet),
        .m_rssi         (m_rssi),
        .m_lqi          (m_lqi),
        .m_packet_length(m_packet_length),
        .m_byte_index   (m_byte_index),
        .m_data_byte    (m_data_byte),
        .m_last         (m_last)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Digit value in bits 3:0; bit 4 flags a character that is not hex.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") begin
            d = c - shpl_pkg::OFS_DIGIT;
        end else if (c >= "A" && c <= "F") begin
            d = c - shpl_pkg::OFS_UPPER;
        end else if (c >= "a" && c <= "f") begin
            d = c - shpl_pkg::OFS_LOWER;
        end else begin
            return 5'h10;
        end
        return {1'b0, d[3:0]};
    endfunction

    function automatic logic [7:0] decode_hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] h;
        logic [4:0] l;
        h = hex_digit(hi);
        l = hex_digit(lo);
        if (h[4] || l[4]) begin
            return 8'h00;
        end
        return {h[3:0], l[3:0]};
    endfunction

    function automatic void drop_line();
        line_len  = '0;
        saw_open  = 1'b0;
        saw_close = 1'b0;
        rssi_acc  = 8'h00;
        lqi_acc   = 8'h00;
        prev_char = 8'h00;
    endfunction

    // Advance the line state by one accepted character; queue the results of
    // a line end when record is set.
    function automatic void parse_char(input logic [7:0] c, input bit record);
        int unsigned  pos;
        int unsigned  len;
        int unsigned  count;
        line_result_t r;
        pos = line_len;
        // A full line swallows whatever comes next, CR and LF included.
        if (pos >= LINE_CHARS - 1) begin
            drop_line();
            return;
        end
        if (c == shpl_pkg::CH_CR) begin
            if (saw_open && saw_close && pos >= shpl_pkg::POS_HDR) begin
                len = (pos - shpl_pkg::POS_HDR) / 2;
                if (len > shpl_pkg::STORE_DEPTH) begin
                    len = shpl_pkg::STORE_DEPTH;
                end
                // A packet with no data still answers with one result.
                count = (len == 0) ? 1 : len;
                for (int k = 0; k < count; k++) begin
                    r.is_packet     = 1'b1;
                    r.rssi          = rssi_acc;
                    r.lqi           = lqi_acc;
                    r.packet_length = len[5:0];
                    r.byte_index    = k[5:0];
                    r.data_byte     = (len == 0) ? 8'h00 : data_mem[k];
                    r.last          = (k == count - 1);
                    if (record) begin
                        pending_results.push_back(r);
                    end
                end
            end else begin
                r      = '0;
                r.last = 1'b1;
                if (record) begin
                    pending_results.push_back(r);
                end
            end
            drop_line();
            return;
        end
        if (c == shpl_pkg::CH_LF) begin
            return;
        end
        if (pos == shpl_pkg::POS_OPEN) begin
            saw_open = (c == shpl_pkg::CH_OPEN);
        end else if (pos == shpl_pkg::POS_CLOSE) begin
            saw_close = (c == shpl_pkg::CH_CLOSE);
        end else if (pos == shpl_pkg::POS_RSSI) begin
            rssi_acc = decode_hex_pair(prev_char, c);
        end else if (pos == shpl_pkg::POS_LQI) begin
            lqi_acc = decode_hex_pair(prev_char, c);
        end else if (pos >= shpl_pkg::POS_DATA && pos % 2 == 1) begin
            if ((pos - shpl_pkg::POS_DATA) / 2 < shpl_pkg::STORE_DEPTH) begin
                data_mem[(pos - shpl_pkg::POS_DATA) / 2] = decode_hex_pair(prev_char, c);
            end
        end
        prev_char = c;
        line_len  = line_len + 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly hex digits of all three kinds; now and then a non-hex character
    // that is neither CR nor LF, so the framing holds.
    function automatic logic [7:0] hex_char();
        int unsigned n;
        logic [7:0]  b;
        logic [4:0]  v;
        n = $urandom_range(99);
        if (n < 6) begin
            b = 8'($urandom_range(255));
            v = hex_digit(b);
            while (!v[4] || b == shpl_pkg::CH_CR || b == shpl_pkg::CH_LF) begin
                b = 8'($urandom_range(255));
                v = hex_digit(b);
            end
            return b;
        end
        n = $urandom_range(21);
        if (n < 10) begin
            return 8'("0" + n);
        end else if (n < 16) begin
            return 8'("A" + n - 10);
        end
        return 8'("a" + n - 16);
    endfunction

    // Present one character, hold it until the transfer, then predict.
    task automatic send_char(input logic [7:0] ch, input bit typed = 1'b0,
                             input line_result_t want = '0);
        @(negedge aclk);
        // Insert random idle cycles ahead of the character.
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_rx_byte <= ch;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (typed) begin
            parse_char(ch, 1'b0);
            pending_results.push_back(want);
        end else begin
            parse_char(ch, 1'b1);
        end
        if (ch != shpl_pkg::CH_LF) begin
            chars_sent++;
        end
    endtask

    // Send a framed line with the given number of data characters, closed by
    // CR. A broken frame spoils one of the two framing marks.
    task automatic send_packet(input int data_chars, input bit broken);
        logic [7:0] frame [$];
        int unsigned at;
        frame.push_back(shpl_pkg::CH_OPEN);
        repeat (4) frame.push_back(hex_char());
        frame.push_back(shpl_pkg::CH_CLOSE);
        repeat (data_chars) frame.push_back(hex_char());
        if (broken) begin
            at = $urandom_range(1) ? shpl_pkg::POS_CLOSE : shpl_pkg::POS_OPEN;
            frame[at] = frame[at] ^ 8'($urandom_range(1, 255));
        end
        foreach (frame[i]) begin
            if ($urandom_range(99) < 8) begin
                send_char(shpl_pkg::CH_LF);
            end
            send_char(frame[i]);
        end
        send_char(shpl_pkg::CH_CR);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pick;
        int          line_no;
        drop_line();
        // Hold reset while the clock runs, then release it on a falling edge, away from the rising edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the scripted rows.
        foreach (script_rows[i]) begin
            send_char(script_rows[i].ch, script_rows[i].typed, script_rows[i].want);
        end

        // Random lines: mostly well-formed packets with short payloads, one
        // line of the full data depth, one line that overruns the buffer,
        // broken frames and noise.
        line_no = 0;
        while (chars_sent < ITEM_TARGET || line_no < MIN_LINES) begin
            steady = (line_no >= 3 && line_no < 7);
            pick   = $urandom_range(99);
            if (line_no == 3) begin
                send_packet(2 * shpl_pkg::STORE_DEPTH, 1'b0);
            end else if (line_no == 9) begin
                // Overrun: either the CR itself or the last data character
                // hits the full line and is dropped.
                send_packet(2 * shpl_pkg::STORE_DEPTH + $urandom_range(1, 2), 1'b0);
            end else if (pick < 65) begin
                send_packet(($urandom_range(99) < 85) ? $urandom_range(0, 16)
                                                      : $urandom_range(17, 40), 1'b0);
            end else if (pick < 78) begin
                send_packet($urandom_range(0, 10), 1'b1);
            end else begin
                // Noise line, at times opened like a packet but cut short.
                if ($urandom_range(1)) begin
                    send_char(shpl_pkg::CH_OPEN);
                end
                repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(255)));
                send_char(shpl_pkg::CH_CR);
            end
            line_no++;
        end
        steady = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays.
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, field checks
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        line_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("is_packet",     want.is_packet,     m_is_packet);
                check_field("rssi",          want.rssi,          m_rssi);
                check_field("lqi",           want.lqi,           m_lqi);
                check_field("packet_length", want.packet_length, m_packet_length);
                check_field("byte_index",    want.byte_index,    m_byte_index);
                check_field("data_byte",     want.data_byte,     m_data_byte);
                check_field("last",          want.last,          m_last);
            end
        end
    end

    // Abort when neither channel completes a transfer for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
src/shpl_pkg.sv
src/shpl_datapath.sv
src/shpl_ctrl.sv
src/serial_hex_packet_line_parser_unit.sv
verif/tb.sv
